// ----- sv/rtyc_pkg.sv -----
// ---------------------------------------------------------------------------
// rtyc_pkg
// Shared types and constants of the RGB to YCbCr MCU converter.
// ---------------------------------------------------------------------------
package rtyc_pkg;

   // MCU geometry and fixed-point format
   localparam int MCU_SIDE      = 16;
   localparam int NUM_COEFS     = 8;
   localparam int COEF_W        = 16;
   localparam int Q_SHIFT       = 15;
   localparam int CHROMA_OFFSET = 128;
   localparam int SAMPLE_MAX    = 255;

   localparam int SAMPLE_W  = 8;
   localparam int POS_W     = 4;
   localparam int LIDX_W    = 8;
   localparam int CIDX_W    = 6;
   localparam int CSR_IDX_W = 8;
   localparam int COEF_IDX_W = $clog2(NUM_COEFS);

   // product of a zero-extended sample and a coefficient, and a three-term sum
   localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
   localparam int SUM_W  = PROD_W + 2;

   // coefficient register indexes
   typedef enum logic [COEF_IDX_W-1:0] {
      REG_COEF_Y_R  = 3'd0,
      REG_COEF_Y_G  = 3'd1,
      REG_COEF_Y_B  = 3'd2,
      REG_COEF_CB_R = 3'd3,
      REG_COEF_HALF = 3'd4,
      REG_COEF_CR_B = 3'd5,
      REG_COEF_CB_G = 3'd6,
      REG_COEF_CR_G = 3'd7
   } coef_reg_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF_RESET [NUM_COEFS] = '{
      16'sd9798, 16'sd19235, 16'sd3736, -16'sd5529,
      16'sd16384, -16'sd2664, -16'sd10855, -16'sd13720
   };

   // live coefficient set handed to the datapath
   typedef struct packed {
      coef_type y_r;
      coef_type y_g;
      coef_type y_b;
      coef_type cb_r;
      coef_type half;
      coef_type cr_b;
      coef_type cb_g;
      coef_type cr_g;
   } coef_set_type;

   // per-pixel side information that travels with the data
   typedef struct packed {
      logic              bank;
      logic [LIDX_W-1:0] luma_index;
      logic [CIDX_W-1:0] chroma_index;
      logic              chroma_valid;
   } pix_meta_type;

endpackage

// ----- sv/rtyc_if.sv -----
// ---------------------------------------------------------------------------
// rtyc interfaces
// Valid/ready channels for pixel requests, results and coefficient writes.
// ---------------------------------------------------------------------------
interface rtyc_req_if;
   import rtyc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] red;
   logic [SAMPLE_W-1:0] green;
   logic [SAMPLE_W-1:0] blue;
   logic [POS_W-1:0]    pix_row;
   logic [POS_W-1:0]    pix_col;
   logic                subsample_420;
   logic                mcu_end;

   modport source (output valid, red, green, blue, pix_row, pix_col,
                   subsample_420, mcu_end, input ready);
   modport sink   (input valid, red, green, blue, pix_row, pix_col,
                   subsample_420, mcu_end, output ready);
endinterface

interface rtyc_rsp_if;
   import rtyc_pkg::*;
   logic                valid;
   logic                ready;
   logic                bank;
   logic [SAMPLE_W-1:0] luma;
   logic [LIDX_W-1:0]   luma_index;
   logic [SAMPLE_W-1:0] chroma_blue;
   logic [SAMPLE_W-1:0] chroma_red;
   logic [CIDX_W-1:0]   chroma_index;
   logic                chroma_valid;

   modport source (output valid, bank, luma, luma_index, chroma_blue, chroma_red,
                   chroma_index, chroma_valid, input ready);
   modport sink   (input valid, bank, luma, luma_index, chroma_blue, chroma_red,
                   chroma_index, chroma_valid, output ready);
endinterface

interface rtyc_csr_if;
   import rtyc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- sv/rtyc_coef_regs.sv -----
// ---------------------------------------------------------------------------
// rtyc_coef_regs
// Coefficient register file; writes beyond the last register are dropped.
// ---------------------------------------------------------------------------
module rtyc_coef_regs (
   input  logic                  clock,
   input  logic                  reset,
   rtyc_csr_if.sink              csr_if,
   output rtyc_pkg::coef_set_type coefs
);
   import rtyc_pkg::*;

   coef_type coef_ff [NUM_COEFS];
   logic     hit;

   assign csr_if.ready = 1'b1;
   assign hit = csr_if.valid && (csr_if.index < CSR_IDX_W'(NUM_COEFS));

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFS; k++) coef_ff[k] <= COEF_RESET[k];
      end else if (hit) begin
         coef_ff[csr_if.index[COEF_IDX_W-1:0]] <= csr_if.wdata;
      end
   end

   // named view for the datapath
   assign coefs.y_r  = coef_ff[REG_COEF_Y_R];
   assign coefs.y_g  = coef_ff[REG_COEF_Y_G];
   assign coefs.y_b  = coef_ff[REG_COEF_Y_B];
   assign coefs.cb_r = coef_ff[REG_COEF_CB_R];
   assign coefs.half = coef_ff[REG_COEF_HALF];
   assign coefs.cr_b = coef_ff[REG_COEF_CR_B];
   assign coefs.cb_g = coef_ff[REG_COEF_CB_G];
   assign coefs.cr_g = coef_ff[REG_COEF_CR_G];

endmodule

// ----- sv/rtyc_pipe.sv -----
// ---------------------------------------------------------------------------
// rtyc_pipe
// Three-stage color conversion: products, sums, scale and clamp.
// ---------------------------------------------------------------------------
module rtyc_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  rtyc_pkg::coef_set_type coefs,
   input  logic                   bank,
   rtyc_req_if.sink               req_if,
   rtyc_rsp_if.source             rsp_if
);
   import rtyc_pkg::*;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // floor by 2^15, optional offset, clamp to 0..255
   function automatic logic [SAMPLE_W-1:0] scale_clamp(input sum_type s,
                                                         input logic offset);
      logic signed [SUM_W-Q_SHIFT-1:0] q;
      logic signed [SUM_W-Q_SHIFT:0]   t;
      q = s[SUM_W-1:Q_SHIFT];
      t = (SUM_W-Q_SHIFT+1)'(q) + (offset ? (SUM_W-Q_SHIFT+1)'(CHROMA_OFFSET) : '0);
      if (t < 0)
         scale_clamp = '0;
      else if (t > (SUM_W-Q_SHIFT+1)'(SAMPLE_MAX))
         scale_clamp = SAMPLE_W'(SAMPLE_MAX);
      else
         scale_clamp = t[SAMPLE_W-1:0];
   endfunction

   // stage flow control
   logic s1_ready, s2_ready, s3_ready;
   logic v1_ff, v2_ff, v3_ff;

   assign s3_ready     = !v3_ff || rsp_if.ready;
   assign s2_ready     = !v2_ff || s3_ready;
   assign s1_ready     = !v1_ff || s2_ready;
   assign req_if.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s1_ready) v1_ff <= req_if.valid;
         if (s2_ready) v2_ff <= v1_ff;
         if (s3_ready) v3_ff <= v2_ff;
      end
   end

   // stage 1: nine products and buffer indexes
   logic signed [SAMPLE_W:0] r_s, g_s, b_s;
   pix_meta_type meta_in, meta1_ff, meta2_ff;
   prod_type yr_ff, yg_ff, yb_ff, cbr_ff, cbg_ff, cbb_ff, crr_ff, crg_ff, crb_ff;

   assign r_s = {1'b0, req_if.red};
   assign g_s = {1'b0, req_if.green};
   assign b_s = {1'b0, req_if.blue};

   always_comb begin
      meta_in.bank = bank;
      if (req_if.subsample_420) begin
         meta_in.luma_index   = LIDX_W'(int'(req_if.pix_row) * MCU_SIDE
                                        + int'(req_if.pix_col));
         meta_in.chroma_index = {req_if.pix_row[3:1], req_if.pix_col[3:1]};
         meta_in.chroma_valid = !req_if.pix_row[0] && !req_if.pix_col[0];
      end else begin
         meta_in.luma_index   = {2'b00, req_if.pix_row[2:0], req_if.pix_col[2:0]};
         meta_in.chroma_index = {req_if.pix_row[2:0], req_if.pix_col[2:0]};
         meta_in.chroma_valid = 1'b1;
      end
   end

   // operands widened to the full product width before the multiply
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         meta1_ff <= meta_in;
         yr_ff    <= PROD_W'(r_s) * PROD_W'(coefs.y_r);
         yg_ff    <= PROD_W'(g_s) * PROD_W'(coefs.y_g);
         yb_ff    <= PROD_W'(b_s) * PROD_W'(coefs.y_b);
         cbr_ff   <= PROD_W'(r_s) * PROD_W'(coefs.cb_r);
         cbg_ff   <= PROD_W'(g_s) * PROD_W'(coefs.cb_g);
         cbb_ff   <= PROD_W'(b_s) * PROD_W'(coefs.half);
         crr_ff   <= PROD_W'(r_s) * PROD_W'(coefs.half);
         crg_ff   <= PROD_W'(g_s) * PROD_W'(coefs.cr_g);
         crb_ff   <= PROD_W'(b_s) * PROD_W'(coefs.cr_b);
      end
   end

   // stage 2: three-term sums
   sum_type y_sum_ff, cb_sum_ff, cr_sum_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         meta2_ff  <= meta1_ff;
         y_sum_ff  <= SUM_W'(yr_ff) + SUM_W'(yg_ff) + SUM_W'(yb_ff);
         cb_sum_ff <= SUM_W'(cbr_ff) + SUM_W'(cbg_ff) + SUM_W'(cbb_ff);
         cr_sum_ff <= SUM_W'(crr_ff) + SUM_W'(crg_ff) + SUM_W'(crb_ff);
      end
   end

   // stage 3: scale, clamp and output register
   logic                bank_ff;
   logic [SAMPLE_W-1:0] luma_ff, cb_ff, cr_ff;
   logic [LIDX_W-1:0]   lidx_ff;
   logic [CIDX_W-1:0]   cidx_ff;
   logic                cvalid_ff;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         bank_ff   <= meta2_ff.bank;
         luma_ff   <= scale_clamp(y_sum_ff, 1'b0);
         lidx_ff   <= meta2_ff.luma_index;
         cvalid_ff <= meta2_ff.chroma_valid;
         if (meta2_ff.chroma_valid) begin
            cb_ff   <= scale_clamp(cb_sum_ff, 1'b1);
            cr_ff   <= scale_clamp(cr_sum_ff, 1'b1);
            cidx_ff <= meta2_ff.chroma_index;
         end else begin
            cb_ff   <= '0;
            cr_ff   <= '0;
            cidx_ff <= '0;
         end
      end
   end

   assign rsp_if.valid        = v3_ff;
   assign rsp_if.bank         = bank_ff;
   assign rsp_if.luma         = luma_ff;
   assign rsp_if.luma_index   = lidx_ff;
   assign rsp_if.chroma_blue  = cb_ff;
   assign rsp_if.chroma_red   = cr_ff;
   assign rsp_if.chroma_index = cidx_ff;
   assign rsp_if.chroma_valid = cvalid_ff;

endmodule

// ----- sv/rgb_to_ycbcr_mcu_converter_unit.sv -----
// ---------------------------------------------------------------------------
// rgb_to_ycbcr_mcu_converter_unit
// RGB888 to YCbCr pixel converter for MCU buffers, with bank tracking.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  req_if    in   red, green, blue, pix_row, pix_col, mode, end    valid/ready
//  rsp_if    out  bank, luma, indexes, chroma_blue/red, c_valid    valid/ready
//  csr_if    in   index, wdata (Q15 coefficient)                   valid/ready
//
//  One pixel per cycle while the result side is ready; each pixel passes the
//  product, sum and clamp stages, the last being the output register.
//  Each stage advances when the one after it is empty or moving, so a
//  stalled result does not block pixels that fill the stages behind it.
//  Synchronous reset empties the pipe, restores the coefficients and sets
//  the bank to 0. csr_if is always ready.
// ---------------------------------------------------------------------------
module rgb_to_ycbcr_mcu_converter_unit (
   input logic        clock,
   input logic        reset,
   rtyc_req_if.sink   req_if,
   rtyc_rsp_if.source rsp_if,
   rtyc_csr_if.sink   csr_if
);
   import rtyc_pkg::*;

   coef_set_type coefs;
   logic         bank_ff, bank_in;

   // bank flips after the last pixel of an MCU is accepted
   assign bank_in = bank_ff ^ (req_if.valid && req_if.ready && req_if.mcu_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
      end else begin
         bank_ff <= bank_in;
      end
   end

   rtyc_coef_regs u_coef_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .coefs  (coefs)
   );

   rtyc_pipe u_pipe (
      .clock  (clock),
      .reset  (reset),
      .coefs  (coefs),
      .bank   (bank_ff),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

// ----- sv/rtyc_checker.sv -----
// ---------------------------------------------------------------------------
// rtyc_checker
// Port-level checks of the converter, bound to the top level.
// ---------------------------------------------------------------------------
module rtyc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] luma,
   input logic [7:0] luma_index,
   input logic [7:0] chroma_blue,
   input logic [7:0] chroma_red,
   input logic [5:0] chroma_index,
   input logic       chroma_valid
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(luma) && $stable(luma_index)
         && $stable(chroma_blue) && $stable(chroma_red))
      else $error("result changed while stalled");

   // pipe is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // dropped chroma reads as zero
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !chroma_valid |-> chroma_blue == 8'd0 && chroma_red == 8'd0
         && chroma_index == 6'd0)
      else $error("chroma not zero when not valid");

   // chroma is dropped only on an odd row or column of a 4:2:0 MCU
   a_chroma_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !chroma_valid |-> luma_index[4] || luma_index[0])
      else $error("chroma dropped on an even position");

endmodule

bind rgb_to_ycbcr_mcu_converter_unit rtyc_checker u_rtyc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .luma         (rsp_if.luma),
   .luma_index   (rsp_if.luma_index),
   .chroma_blue  (rsp_if.chroma_blue),
   .chroma_red   (rsp_if.chroma_red),
   .chroma_index (rsp_if.chroma_index),
   .chroma_valid (rsp_if.chroma_valid)
);

// ----- tb/tb_rgb_to_ycbcr_mcu_converter_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_to_ycbcr_mcu_converter_unit
// Self-checking bench for the RGB to YCbCr MCU converter. A local predictor
// keeps its own Q15 coefficient copy and bank bit, computes the expected
// Y/Cb/Cr, buffer indexes and chroma flag for every accepted pixel request,
// and each result is compared in order. Directed pixels, coefficient extremes
// and dropped coefficient writes come first, then full and broken MCU sequences
// under several coefficient sets, with random gaps on the request side and
// random stalls on the result side.
// ---------------------------------------------------------------------------
module tb_rgb_to_ycbcr_mcu_converter_unit;
   import rtyc_pkg::*;

   localparam int       PIPE_LATENCY  = 3;
   localparam int       CYCLE_LIMIT   = 200000;
   localparam int       SIDE_444      = 8;
   localparam int       PHASE_PIXELS  = 120;
   localparam int       NUM_PHASES    = 6;
   localparam coef_type COEF_POS_MAX  = 16'sh7FFF;
   localparam coef_type COEF_NEG_MAX  = 16'sh8000;

   typedef struct {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [POS_W-1:0]    pix_row;
      logic [POS_W-1:0]    pix_col;
      logic                subsample_420;
      logic                mcu_end;
   } pixel_type;

   typedef struct {
      logic                bank;
      logic [SAMPLE_W-1:0] luma;
      logic [LIDX_W-1:0]   luma_index;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] chroma_red;
      logic [CIDX_W-1:0]   chroma_index;
      logic                chroma_valid;
   } ycc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtyc_req_if req_ch ();
   rtyc_rsp_if rsp_ch ();
   rtyc_csr_if csr_ch ();

   rgb_to_ycbcr_mcu_converter_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predictor state and expected results
   coef_type    coef_live [NUM_COEFS];
   logic        bank_live;
   ycc_type     ycc_expected [$];
   int unsigned error_count  = 0;
   int unsigned pixels_sent  = 0;
   int unsigned cycle_count  = 0;
   bit          req_gaps_on  = 1'b0;
   bit          rsp_stalls_on = 1'b0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // floor by 2^15, offset, clamp to a sample
   function automatic logic [SAMPLE_W-1:0] scale_to_sample(longint acc, int offset);
      longint q;
      q = (acc >>> Q_SHIFT) + offset;
      if (q > SAMPLE_MAX) q = SAMPLE_MAX;
      if (q < 0) q = 0;
      return q[SAMPLE_W-1:0];
   endfunction

   function automatic longint weigh(pixel_type p, coef_type kr, coef_type kg,
                                    coef_type kb);
      return longint'(p.red) * longint'(kr) + longint'(p.green) * longint'(kg)
           + longint'(p.blue) * longint'(kb);
   endfunction

   // expected result of one pixel under the live coefficients and bank
   function automatic ycc_type convert_pixel(pixel_type p);
      ycc_type y;
      y.bank = bank_live;
      y.luma = scale_to_sample(weigh(p, coef_live[REG_COEF_Y_R], coef_live[REG_COEF_Y_G],
                                     coef_live[REG_COEF_Y_B]), 0);
      if (p.subsample_420) begin
         y.luma_index   = LIDX_W'(int'(p.pix_row) * MCU_SIDE + int'(p.pix_col));
         y.chroma_index = {p.pix_row[3:1], p.pix_col[3:1]};
         y.chroma_valid = !p.pix_row[0] && !p.pix_col[0];
      end else begin
         // positions wrap to the 8x8 block
         y.luma_index   = {2'b00, p.pix_row[2:0], p.pix_col[2:0]};
         y.chroma_index = {p.pix_row[2:0], p.pix_col[2:0]};
         y.chroma_valid = 1'b1;
      end
      if (y.chroma_valid) begin
         y.chroma_blue = scale_to_sample(weigh(p, coef_live[REG_COEF_CB_R],
                                               coef_live[REG_COEF_CB_G],
                                               coef_live[REG_COEF_HALF]), CHROMA_OFFSET);
         y.chroma_red  = scale_to_sample(weigh(p, coef_live[REG_COEF_HALF],
                                               coef_live[REG_COEF_CR_G],
                                               coef_live[REG_COEF_CR_B]), CHROMA_OFFSET);
      end else begin
         // skipped chroma reads back as zero
         y.chroma_blue  = '0;
         y.chroma_red   = '0;
         y.chroma_index = '0;
      end
      return y;
   endfunction

   function automatic pixel_type make_pixel(int r, int g, int b, int row, int col,
                                            bit sub, bit last);
      pixel_type p;
      p.red           = SAMPLE_W'(r);
      p.green         = SAMPLE_W'(g);
      p.blue          = SAMPLE_W'(b);
      p.pix_row       = POS_W'(row);
      p.pix_col       = POS_W'(col);
      p.subsample_420 = sub;
      p.mcu_end       = last;
      return p;
   endfunction

   // samples lean toward the rails so the clamps get hit
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   function automatic pixel_type random_pixel(int row, int col, bit sub, bit last);
      return make_pixel(int'(pick_sample()), int'(pick_sample()), int'(pick_sample()),
                        row, col, sub, last);
   endfunction

   // send one pixel request and record its expected result
   task automatic send_pixel(pixel_type p);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.red           <= p.red;
      req_ch.green         <= p.green;
      req_ch.blue          <= p.blue;
      req_ch.pix_row       <= p.pix_row;
      req_ch.pix_col       <= p.pix_col;
      req_ch.subsample_420 <= p.subsample_420;
      req_ch.mcu_end       <= p.mcu_end;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ycc_expected.push_back(convert_pixel(p));
      if (p.mcu_end) bank_live = ~bank_live;
      pixels_sent++;
   endtask

   // coefficient write; out-of-range indexes are dropped by the block
   task automatic write_coef(int unsigned index, coef_type value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_IDX_W'(index);
      csr_ch.wdata <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (index < NUM_COEFS) coef_live[index] = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic load_coefs(input coef_type weights [NUM_COEFS]);
      for (int k = 0; k < NUM_COEFS; k++) write_coef(k, weights[k]);
   endtask

   // stop requests and wait until every result is back
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (ycc_expected.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // one MCU in raster order, cut short after stop_at pixels, end mark on the last pixel sent
   task automatic send_mcu(bit sub, int unsigned stop_at);
      int side;
      int unsigned n;
      side = sub ? MCU_SIDE : SIDE_444;
      n = 0;
      for (int row = 0; row < side; row++) begin
         for (int col = 0; col < side; col++) begin
            n++;
            if (n > stop_at) return;
            send_pixel(random_pixel(row, col, sub,
                                    (n == stop_at) || (row == side - 1 && col == side - 1)));
         end
      end
   endtask

   task automatic check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what,
                  want_v, got_v);
         error_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      ycc_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (ycc_expected.size() == 0) begin
            $display("%0t ns: result with no request pending, expected none, actual luma %0d",
                     $time, rsp_ch.luma);
            error_count++;
         end else begin
            want = ycc_expected.pop_front();
            check_field("bank",         8'(want.bank),         8'(rsp_ch.bank));
            check_field("luma",         want.luma,             rsp_ch.luma);
            check_field("luma_index",   want.luma_index,       rsp_ch.luma_index);
            check_field("chroma_blue",  want.chroma_blue,      rsp_ch.chroma_blue);
            check_field("chroma_red",   want.chroma_red,       rsp_ch.chroma_red);
            check_field("chroma_index", 8'(want.chroma_index), 8'(rsp_ch.chroma_index));
            check_field("chroma_valid", 8'(want.chroma_valid), 8'(rsp_ch.chroma_valid));
         end
      end
   end

   // result side: random stall before each result
   initial begin : result_drain
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      forever begin
         hold = rsp_stalls_on ? $urandom_range(0, 3) : 0;
         repeat (hold) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1 || reset);
      end
   end

   // corners of the color cube, position wrap, chroma skip, bank flips
   task automatic test_directed_pixels();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_pixel(make_pixel(  0,   0,   0,  0,  0, 0, 0));
      send_pixel(make_pixel(255, 255, 255,  7,  7, 0, 0));
      send_pixel(make_pixel(255,   0,   0,  0,  7, 0, 0));
      send_pixel(make_pixel(  0, 255,   0,  7,  0, 0, 0));
      send_pixel(make_pixel(  0,   0, 255,  3,  4, 0, 0));
      send_pixel(make_pixel(255, 255,   0, 15, 15, 0, 0));
      send_pixel(make_pixel(  0, 255, 255,  8,  9, 0, 0));
      send_pixel(make_pixel(255,   0, 255, 12,  3, 0, 1));
      send_pixel(make_pixel(128, 128, 128,  0,  0, 1, 0));
      send_pixel(make_pixel(200,  10,  90,  1,  0, 1, 0));
      send_pixel(make_pixel( 10, 200,  90,  0,  1, 1, 0));
      send_pixel(make_pixel(255, 255, 255, 15, 15, 1, 0));
      send_pixel(make_pixel(  0,   0,   0, 14, 14, 1, 0));
      send_pixel(make_pixel( 17,  99, 240, 15, 14, 1, 1));
      send_pixel(make_pixel(  1,   2,   3,  0,  0, 0, 1));
      send_pixel(make_pixel(254,   1, 127,  5,  6, 1, 0));
      drain_results();
   endtask

   // every coefficient at the rails, then back to the defaults
   task automatic test_coef_extremes();
      coef_type weights [NUM_COEFS];
      for (int set_no = 0; set_no < 3; set_no++) begin
         for (int k = 0; k < NUM_COEFS; k++) begin
            case (set_no)
               0:       weights[k] = COEF_POS_MAX;
               1:       weights[k] = COEF_NEG_MAX;
               default: weights[k] = (k % 2 != 0) ? COEF_NEG_MAX : COEF_POS_MAX;
            endcase
         end
         load_coefs(weights);
         send_pixel(make_pixel(255, 255, 255, 2, 5, 0, 0));
         send_pixel(make_pixel(255,   0, 255, 0, 0, 1, 0));
         send_pixel(make_pixel(  0, 255,   0, 6, 1, 0, 0));
         drain_results();
      end
      load_coefs(COEF_RESET);
   endtask

   // writes beyond the last register must leave the coefficients alone
   task automatic test_ignored_index();
      write_coef(NUM_COEFS, coef_type'($urandom_range(0, 65535)));
      write_coef((1 << CSR_IDX_W) - 1, COEF_NEG_MAX);
      write_coef($urandom_range(NUM_COEFS, (1 << CSR_IDX_W) - 1),
                 coef_type'($urandom_range(0, 65535)));
      send_pixel(make_pixel(255, 128, 0, 4, 4, 0, 0));
      send_pixel(make_pixel(30, 60, 90, 2, 2, 1, 0));
      drain_results();
   endtask

   // mostly full MCUs, some truncated MCUs and loose pixels, per coefficient set
   task automatic test_random_mcus();
      coef_type    weights [NUM_COEFS];
      int unsigned start_count;
      int unsigned pick;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int k = 0; k < NUM_COEFS; k++) begin
            case (phase)
               0:       weights[k] = COEF_RESET[k];
               2:       weights[k] = coef_type'(int'($urandom_range(0, 40000)) - 20000);
               3:       weights[k] = COEF_POS_MAX;
               4:       weights[k] = COEF_NEG_MAX;
               default: weights[k] = coef_type'($urandom_range(0, 65535));
            endcase
         end
         load_coefs(weights);
         start_count = pixels_sent;
         while (pixels_sent - start_count < PHASE_PIXELS) begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               send_mcu(1'b0, SIDE_444 * SIDE_444);
            end else if (pick < 7) begin
               send_mcu(1'b1, MCU_SIDE * MCU_SIDE);
            end else if (pick < 8) begin
               // MCU cut short with an early end mark
               send_mcu(1'($urandom_range(0, 1)),
                        $urandom_range(1, SIDE_444 * SIDE_444 - 1));
            end else begin
               repeat ($urandom_range(1, 8))
                  send_pixel(random_pixel($urandom_range(0, 15), $urandom_range(0, 15),
                                          1'($urandom_range(0, 1)),
                                          $urandom_range(0, 3) == 0));
            end
         end
         drain_results();
      end
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.red           = '0;
      req_ch.green         = '0;
      req_ch.blue          = '0;
      req_ch.pix_row       = '0;
      req_ch.pix_col       = '0;
      req_ch.subsample_420 = 1'b0;
      req_ch.mcu_end       = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.wdata         = '0;
      coef_live            = COEF_RESET;
      bank_live            = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_pixels();
      test_coef_extremes();
      test_ignored_index();
      test_random_mcus();
      drain_results();

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- rgb_to_ycbcr_mcu_converter_unit.f -----
sv/rtyc_pkg.sv
sv/rtyc_if.sv
sv/rtyc_coef_regs.sv
sv/rtyc_pipe.sv
sv/rgb_to_ycbcr_mcu_converter_unit.sv
sv/rtyc_checker.sv
tb/tb_rgb_to_ycbcr_mcu_converter_unit.sv
